// ===== src/sps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stroke simplifier package
// Item types, edit codes, threshold constants and shared widths.
// ----------------------------------------------------------------------------
package sps_pkg;

  // Default depth of the raw point buffer of the current segment.
  localparam int MAX_POINTS_DEF = 256;

  // Q0.16 threshold factors, rounded to nearest.
  localparam logic [11:0] CLOSE_Q = 12'd3277;  // 0.05
  localparam logic [11:0] SHORT_Q = 12'd492;   // 0.0075
  localparam logic [11:0] DEV_Q   = 12'd164;   // 0.0025

  // Operand and product widths of the shared multiplier.
  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = 35;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Input commands.
  localparam logic CMD_PEN_DOWN = 1'b0;
  localparam logic CMD_PEN_MOVE = 1'b1;

  // Configuration register indexes.
  localparam logic REG_CANVAS_WIDTH  = 1'b0;
  localparam logic REG_CANVAS_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    EDIT_START   = 2'd0,
    EDIT_APPEND  = 2'd1,
    EDIT_REPLACE = 2'd2
  } edit_op_e;

  typedef struct packed {
    logic               command;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
  } sps_in_t;

  typedef struct packed {
    edit_op_e           edit_op;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic               last_edit;
  } sps_out_t;

endpackage

// ===== src/sps_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sps_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiply with the product registered, one product per cycle.
// ----------------------------------------------------------------------------
module sps_mul import sps_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  logic signed [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== src/stroke_polyline_simplifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stroke polyline simplifier core
// Turns pen-down and pen-move samples into edits of a simplified polyline.
// ----------------------------------------------------------------------------
// Usage:
// Input items (command, x_coord, y_coord) arrive on in_item_i with
// in_valid_i; the core raises in_stall_o while it works on an item. Edit
// items leave on out_item_o with out_valid_o and are held while out_stall_i
// is high. A pen down gives a start-subpath and an append-vertex item, or
// nothing when it lands close to the last vertex. A pen move gives one item,
// or nothing while no vertex exists yet. Every product goes through one
// shared multiplier. A pen move that runs the deviation test walks the n
// buffered points two products per point. The core accepts the next item
// as soon as its last edit is loaded into the output register, even while
// that edit still waits on a stall. A stalled receiver only holds off the
// loading of further edits. Reset clears the vertex state and empties the
// buffer; no clearing pass runs, the buffer RAM is read only where it was
// written. Canvas size registers sit on the APB port; the user must write
// them only while idle, and the core itself does not enforce this.
// ----------------------------------------------------------------------------
module stroke_polyline_simplifier_core import sps_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sps_in_t     in_item_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output sps_out_t    out_item_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CNT_W  = AW + 1;
  localparam int ACC_W  = 54;
  localparam int SUM_W  = 34 + AW;
  localparam int CMP_W  = (SUM_W + 16 > ACC_W) ? SUM_W + 16 : ACC_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_W0    = 4'd1;   // dx^2
  localparam logic [3:0] S_W1    = 4'd2;   // dy^2
  localparam logic [3:0] S_W2    = 4'd3;   // m * k
  localparam logic [3:0] S_W3    = 4'd4;   // (m * k)^2
  localparam logic [3:0] S_W4    = 4'd5;   // distance decision
  localparam logic [3:0] S_L0    = 4'd6;   // cx^2
  localparam logic [3:0] S_L1    = 4'd7;   // cy^2
  localparam logic [3:0] S_L2    = 4'd8;   // m * DEV
  localparam logic [3:0] S_L3    = 4'd9;   // m * DEV * L^2
  localparam logic [3:0] S_L4    = 4'd10;  // start the buffer walk
  localparam logic [3:0] S_LOOP  = 4'd11;
  localparam logic [3:0] S_DRAIN = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  logic [3:0] state_q, state_d;

  // Configuration.
  logic [12:0] width_q, width_d, height_q, height_d;
  logic [12:0] side_min;
  logic        cfg_we;

  // Item and kept state.
  logic               cmd_q, cmd_d;
  logic signed [15:0] x_q, x_d, y_q, y_d;
  logic               has_v_q, has_v_d;
  logic signed [15:0] lv_x_q, lv_x_d, lv_y_q, lv_y_d;
  logic signed [15:0] base_x_q, base_x_d, base_y_q, base_y_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // Datapath.
  logic signed [16:0] cx_q, cx_d, cy_q, cy_d, py_q, py_d;
  logic signed [16:0] dx, dy, px, py;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic               ph_q, ph_d;
  logic signed [34:0] c1_q, c1_d, diff_q, diff_d, diff_neg;
  logic [33:0]        diff_abs;
  logic               m2_v_q, m2_v_d, d_v_q, d_v_d;
  logic               near, deviant, more;

  // Output.
  edit_op_e  res_op_q, res_op_d;
  logic      pend_two_q, pend_two_d;
  logic      out_valid_q, out_valid_d;
  sps_out_t  out_q, out_d;

  // Shared multiplier and buffer RAM.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [31:0]               ram_wdata, ram_rdata;
  logic signed [15:0]        rd_x, rd_y;

  sps_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  sps_ram #(
    .WIDTH (32),
    .DEPTH (MAX_POINTS)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_x = ram_rdata[31:16];
  assign rd_y = ram_rdata[15:0];

  // The APB port is always ready; reads return the selected size.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_CANVAS_HEIGHT) ? {19'b0, height_q} : {19'b0, width_q};

  assign side_min = (width_q < height_q) ? width_q : height_q;

  // Offsets from the last vertex, and of a buffered point from the segment base.
  assign dx = {x_q[15], x_q} - {lv_x_q[15], lv_x_q};
  assign dy = {y_q[15], y_q} - {lv_y_q[15], lv_y_q};
  assign px = {rd_x[15], rd_x} - {base_x_q[15], base_x_q};
  assign py = {rd_y[15], rd_y} - {base_y_q[15], base_y_q};

  assign diff_neg = -diff_q;
  assign diff_abs = diff_q[34] ? diff_neg[33:0] : diff_q[33:0];

  // Squared distance below 2^18 and d^2 * 2^32 < (m*k)^2.
  assign near = (acc_q[ACC_W-1:18] == '0) && ({3'b0, acc_q[17:0], 32'b0} < mul_p[52:0]);
  assign deviant = CMP_W'({sum_q, 16'b0}) > CMP_W'(acc_q);
  assign more = (CNT_W'(idx_q) + CNT_W'(1)) < cnt_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    width_d    = width_q;
    height_d   = height_q;
    cmd_d      = cmd_q;
    x_d        = x_q;
    y_d        = y_q;
    has_v_d    = has_v_q;
    lv_x_d     = lv_x_q;
    lv_y_d     = lv_y_q;
    base_x_d   = base_x_q;
    base_y_d   = base_y_q;
    cnt_d      = cnt_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    py_d       = py_q;
    acc_d      = acc_q;
    sum_d      = sum_q;
    idx_d      = idx_q;
    ph_d       = ph_q;
    c1_d       = c1_q;
    diff_d     = diff_q;
    res_op_d   = res_op_q;
    pend_two_d = pend_two_q;
    out_d      = out_q;
    mul_a      = '0;
    mul_b      = '0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = {x_q, y_q};
    ram_re     = 1'b0;
    ram_raddr  = '0;

    if (cfg_we) begin
      if (paddr[2] == REG_CANVAS_WIDTH) begin
        width_d = pwdata[12:0];
      end else begin
        height_d = pwdata[12:0];
      end
    end

    // Cross product pipeline behind the buffer walk: difference, then sum of magnitudes.
    m2_v_d = 1'b0;
    d_v_d  = m2_v_q;
    if (m2_v_q) begin
      diff_d = c1_q - mul_p[34:0];
    end
    if (d_v_q) begin
      sum_d = sum_q + SUM_W'(diff_abs);
    end

    // A finished edit leaves the output register when the receiver takes it.
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_item_i.command;
          x_d     = in_item_i.x_coord;
          y_d     = in_item_i.y_coord;
          state_d = S_W0;
        end
      end
      S_W0: begin
        mul_a = MUL_A_W'(dx);
        mul_b = MUL_B_W'(dx);
        cx_d  = {x_q[15], x_q} - {base_x_q[15], base_x_q};
        cy_d  = {y_q[15], y_q} - {base_y_q[15], base_y_q};
        if (cmd_q == CMD_PEN_MOVE && !has_v_q) begin
          state_d = S_IDLE;
        end else begin
          if (cmd_q == CMD_PEN_MOVE && cnt_q < CNT_W'(MAX_POINTS)) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_q[AW-1:0];
            cnt_d     = cnt_q + CNT_W'(1);
          end
          state_d = S_W1;
        end
      end
      S_W1: begin
        mul_a   = MUL_A_W'(dy);
        mul_b   = MUL_B_W'(dy);
        acc_d   = ACC_W'(mul_p[33:0]);
        state_d = S_W2;
      end
      S_W2: begin
        mul_a   = MUL_A_W'(side_min);
        mul_b   = MUL_B_W'((cmd_q == CMD_PEN_DOWN) ? CLOSE_Q : SHORT_Q);
        acc_d   = acc_q + ACC_W'(mul_p[33:0]);
        state_d = S_W3;
      end
      S_W3: begin
        mul_a   = MUL_A_W'(mul_p[25:0]);
        mul_b   = MUL_B_W'(mul_p[25:0]);
        state_d = S_W4;
      end
      S_W4: begin
        if (cmd_q == CMD_PEN_DOWN) begin
          if (has_v_q && near) begin
            state_d = S_IDLE;
          end else begin
            has_v_d    = 1'b1;
            lv_x_d     = x_q;
            lv_y_d     = y_q;
            base_x_d   = x_q;
            base_y_d   = y_q;
            ram_we     = 1'b1;
            cnt_d      = CNT_W'(1);
            pend_two_d = 1'b1;
            res_op_d   = EDIT_APPEND;
            state_d    = S_EMIT;
          end
        end else if (near) begin
          lv_x_d     = x_q;
          lv_y_d     = y_q;
          pend_two_d = 1'b0;
          res_op_d   = EDIT_REPLACE;
          state_d    = S_EMIT;
        end else begin
          state_d = S_L0;
        end
      end
      S_L0: begin
        mul_a   = MUL_A_W'(cx_q);
        mul_b   = MUL_B_W'(cx_q);
        state_d = S_L1;
      end
      S_L1: begin
        mul_a   = MUL_A_W'(cy_q);
        mul_b   = MUL_B_W'(cy_q);
        acc_d   = ACC_W'(mul_p[33:0]);
        state_d = S_L2;
      end
      S_L2: begin
        mul_a   = MUL_A_W'(side_min);
        mul_b   = MUL_B_W'(DEV_Q);
        acc_d   = acc_q + ACC_W'(mul_p[33:0]);
        state_d = S_L3;
      end
      S_L3: begin
        mul_a   = MUL_A_W'(mul_p[20:0]);
        mul_b   = MUL_B_W'(acc_q[33:0]);
        state_d = S_L4;
      end
      S_L4: begin
        acc_d     = mul_p[ACC_W-1:0];
        sum_d     = '0;
        ram_re    = 1'b1;
        idx_d     = '0;
        ph_d      = 1'b0;
        state_d   = S_LOOP;
      end
      S_LOOP: begin
        if (!ph_q) begin
          mul_a = MUL_A_W'(px);
          mul_b = MUL_B_W'(cy_q);
          py_d  = py;
          ph_d  = 1'b1;
        end else begin
          mul_a  = MUL_A_W'(py_q);
          mul_b  = MUL_B_W'(cx_q);
          c1_d   = mul_p[34:0];
          m2_v_d = 1'b1;
          ph_d   = 1'b0;
          if (more) begin
            ram_re    = 1'b1;
            ram_raddr = idx_q + AW'(1);
            idx_d     = idx_q + AW'(1);
          end else begin
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (!m2_v_q && !d_v_q) begin
          lv_x_d     = x_q;
          lv_y_d     = y_q;
          pend_two_d = 1'b0;
          if (deviant) begin
            res_op_d = EDIT_APPEND;
            base_x_d = x_q;
            base_y_d = y_q;
            ram_we   = 1'b1;
            cnt_d    = CNT_W'(1);
          end else begin
            res_op_d = EDIT_REPLACE;
          end
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d    = 1'b1;
          out_d.vertex_x = x_q;
          out_d.vertex_y = y_q;
          if (pend_two_q) begin
            out_d.edit_op   = EDIT_START;
            out_d.last_edit = 1'b0;
            pend_two_d      = 1'b0;
          end else begin
            out_d.edit_op   = res_op_q;
            out_d.last_edit = 1'b1;
            state_d         = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= 13'd640;
      height_q    <= 13'd480;
      has_v_q     <= 1'b0;
      lv_x_q      <= '0;
      lv_y_q      <= '0;
      cnt_q       <= '0;
      m2_v_q      <= 1'b0;
      d_v_q       <= 1'b0;
      pend_two_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      width_q     <= width_d;
      height_q    <= height_d;
      has_v_q     <= has_v_d;
      lv_x_q      <= lv_x_d;
      lv_y_q      <= lv_y_d;
      cnt_q       <= cnt_d;
      m2_v_q      <= m2_v_d;
      d_v_q       <= d_v_d;
      pend_two_q  <= pend_two_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    x_q      <= x_d;
    y_q      <= y_d;
    base_x_q <= base_x_d;
    base_y_q <= base_y_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    py_q     <= py_d;
    acc_q    <= acc_d;
    sum_q    <= sum_d;
    idx_q    <= idx_d;
    ph_q     <= ph_d;
    c1_q     <= c1_d;
    diff_q   <= diff_d;
    res_op_q <= res_op_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== src/sps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stroke simplifier checker
// Port-level assertions on the item channels, bound to the core.
// ----------------------------------------------------------------------------
module sps_checker import sps_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input sps_out_t out_item_o
);

  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Every accepted item keeps the core busy in the cycle after it is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("core took two items in consecutive cycles");

  // A waiting edit holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled edit changed or vanished");

  // Only the start of a subpath is followed by another edit of the same item.
  a_not_last_is_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.last_edit) |-> (out_item_o.edit_op == EDIT_START))
    else $error("non-final edit is not a subpath start");

  // A taken subpath start is followed at once by the append at the same point.
  a_start_then_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_item_o.edit_op == EDIT_START) |=>
      (out_valid_o && out_item_o.edit_op == EDIT_APPEND && out_item_o.last_edit &&
       out_item_o.vertex_x == $past(out_item_o.vertex_x) &&
       out_item_o.vertex_y == $past(out_item_o.vertex_y)))
    else $error("subpath start not followed by its append");

endmodule

bind stroke_polyline_simplifier_core sps_checker u_sps_checker (.*);
